>>> hw/rtl/resp_multibulk_request_parser_defines.svh
// ----------------------------------------------------------------------------
// RESP multibulk request parser: assertion macros
// Shorthand for the clocked, reset-gated properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RESP_MULTIBULK_REQUEST_PARSER_DEFINES_SVH
`define RESP_MULTIBULK_REQUEST_PARSER_DEFINES_SVH

// same-cycle implication
`define RMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rmp_pkg.sv
// ----------------------------------------------------------------------------
// rmp_pkg
// Types and constants shared by the RESP multibulk request parser files.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int COUNT_BITS  = 11;
  localparam int LENGTH_BITS = 30;
  localparam int LINE_BITS   = 7;
  localparam int NUM_BITS    = LENGTH_BITS + 1;
  localparam int INDEX_BITS  = 10;
  localparam int USED_BITS   = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = LENGTH_BITS;

  localparam logic [COUNT_BITS-1:0]  MAX_ARRAY_RST = COUNT_BITS'(1024);
  localparam logic [LENGTH_BITS-1:0] MAX_BULK_RST  = LENGTH_BITS'(512 * 1024 * 1024);
  localparam logic [LINE_BITS-1:0]   MAX_LINE_RST  = LINE_BITS'(64);

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ARRAY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_BULK  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LINE  = 2'd2;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ARG_DONE = 2'd1;
  localparam logic [1:0] KIND_CMD_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [2:0] ERR_EXP_ARRAY = 3'd0;
  localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
  localparam logic [2:0] ERR_EXP_BULK  = 3'd2;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd3;
  localparam logic [2:0] ERR_NO_CRLF   = 3'd4;

  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } rmp_req_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             payload_byte;
    logic [INDEX_BITS-1:0]  arg_index;
    logic [LENGTH_BITS-1:0] arg_length;
    logic [COUNT_BITS-1:0]  arg_count;
    logic [2:0]             error_code;
    logic [USED_BITS-1:0]   consumed_bytes;
  } rmp_resp_t;

endpackage

>>> hw/rtl/resp_multibulk_request_parser.sv
// ----------------------------------------------------------------------------
// resp_multibulk_request_parser
// Incremental parser for RESP arrays of bulk strings, one byte per request.
// ----------------------------------------------------------------------------
// Takes one request (a stream byte or a restart) per clock and parses
// '*'<count>CRLF then, per argument, '$'<len>CRLF<data>CRLF. Each data byte,
// each finished argument and each finished command comes out as one result;
// the last argument's trailer yields only the command-finished result. A
// protocol error yields one error result, after which bytes are dropped until
// a restart request. Throughput is one request per cycle when not stalled;
// requests pass the input register and the result register, with all parsing
// done in the single state-update stage between them. Input stalls only while
// a result sits in the output register and out_stall is high. The user must
// write limits through the cfg port while the parser is idle; it is not enforced.
module resp_multibulk_request_parser
  import rmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rmp_req_t              in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rmp_resp_t             out_resp,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [7:0] {
    PH_WAIT_ARRAY = 8'b0000_0001,
    PH_COUNT_LINE = 8'b0000_0010,
    PH_WAIT_BULK  = 8'b0000_0100,
    PH_LEN_LINE   = 8'b0000_1000,
    PH_DATA       = 8'b0001_0000,
    PH_TRAIL1     = 8'b0010_0000,
    PH_TRAIL2     = 8'b0100_0000,
    PH_HALTED     = 8'b1000_0000
  } phase_t;

  localparam logic [NUM_BITS-1:0]  NUM_CAP  = {NUM_BITS{1'b1}};
  localparam logic [USED_BITS-1:0] USED_MAX = {USED_BITS{1'b1}};

  logic [COUNT_BITS-1:0]  max_array_r;
  logic [LENGTH_BITS-1:0] max_bulk_r;
  logic [LINE_BITS-1:0]   max_line_r;

  logic      in_valid_r;
  rmp_req_t  in_req_r;
  logic      out_valid_r;
  rmp_resp_t out_resp_r;

  phase_t                 phase_r, phase_nxt;
  logic [LINE_BITS-1:0]   line_bytes_r, line_bytes_nxt;
  logic [NUM_BITS-1:0]    num_r, num_nxt;
  logic                   neg_r, neg_nxt;
  logic                   has_digit_r, has_digit_nxt;
  logic                   bad_r, bad_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic [COUNT_BITS-1:0]  exp_args_r, exp_args_nxt;
  logic [COUNT_BITS-1:0]  cur_arg_r, cur_arg_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [LENGTH_BITS-1:0] arg_len_r, arg_len_nxt;
  logic                   trail_ok_r, trail_ok_nxt;
  logic [USED_BITS-1:0]   cmd_bytes_r, cmd_bytes_nxt;

  logic                   blocked;
  logic                   fire;
  logic [7:0]             b;
  logic                   res_valid;
  rmp_resp_t              res;
  logic                   lf_done;
  logic                   too_long;
  logic                   is_digit;
  logic [NUM_BITS+3:0]    num_prod;
  logic [NUM_BITS-1:0]    num_acc;
  logic                   num_base_ok;
  logic                   count_ok;
  logic                   len_ok;
  logic [USED_BITS-1:0]   cmd_inc;
  logic                   last_arg;

  assign blocked   = out_valid_r && out_stall;
  assign fire      = in_valid_r && !blocked;
  assign in_stall  = in_valid_r && blocked;
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;
  assign b         = in_req_r.data_byte;

  // line byte evaluation against the current line state
  assign lf_done  = prev_cr_r && (b == CHR_LF);
  assign too_long = !lf_done && (line_bytes_r >= max_line_r);
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign num_prod = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} +
                    {(NUM_BITS)'(0), b[3:0]};
  assign num_acc  = (num_prod > {4'b0000, NUM_CAP}) ? NUM_CAP : num_prod[NUM_BITS-1:0];

  assign num_base_ok = has_digit_r && !bad_r;
  assign count_ok = num_base_ok &&
                    (neg_r ? (num_r == '0) : (num_r <= NUM_BITS'(max_array_r)));
  assign len_ok   = num_base_ok &&
                    (neg_r ? (num_r == '0) : (num_r <= NUM_BITS'(max_bulk_r)));

  assign cmd_inc  = (cmd_bytes_r < USED_MAX) ? cmd_bytes_r + 1'b1 : cmd_bytes_r;
  assign last_arg = ({1'b0, cur_arg_r} + 1'b1) >= {1'b0, exp_args_r};

  always_comb begin
    phase_nxt      = phase_r;
    line_bytes_nxt = line_bytes_r;
    num_nxt        = num_r;
    neg_nxt        = neg_r;
    has_digit_nxt  = has_digit_r;
    bad_nxt        = bad_r;
    prev_cr_nxt    = prev_cr_r;
    exp_args_nxt   = exp_args_r;
    cur_arg_nxt    = cur_arg_r;
    bytes_left_nxt = bytes_left_r;
    arg_len_nxt    = arg_len_r;
    trail_ok_nxt   = trail_ok_r;
    cmd_bytes_nxt  = cmd_bytes_r;
    res_valid      = 1'b0;
    res            = '0;

    if (fire) begin
      if (in_req_r.action == ACT_RESTART) begin
        phase_nxt      = PH_WAIT_ARRAY;
        line_bytes_nxt = '0;
        num_nxt        = '0;
        neg_nxt        = 1'b0;
        has_digit_nxt  = 1'b0;
        bad_nxt        = 1'b0;
        prev_cr_nxt    = 1'b0;
        exp_args_nxt   = '0;
        cur_arg_nxt    = '0;
        bytes_left_nxt = '0;
        arg_len_nxt    = '0;
        trail_ok_nxt   = 1'b0;
        cmd_bytes_nxt  = '0;
      end else begin
        if ((phase_r != PH_HALTED) && (phase_r != PH_WAIT_ARRAY)) begin
          cmd_bytes_nxt = cmd_inc;
        end
        // shared line-content update for count and length lines
        if (((phase_r == PH_COUNT_LINE) || (phase_r == PH_LEN_LINE)) &&
            !lf_done && !too_long) begin
          bad_nxt     = bad_r | prev_cr_r;
          prev_cr_nxt = 1'b0;
          if (b == CHR_CR) begin
            prev_cr_nxt = 1'b1;
          end else if ((b == CHR_MINUS) && (line_bytes_r == '0)) begin
            neg_nxt = 1'b1;
          end else if (is_digit) begin
            has_digit_nxt = 1'b1;
            num_nxt       = num_acc;
          end else begin
            bad_nxt = 1'b1;
          end
          line_bytes_nxt = line_bytes_r + 1'b1;
        end

        case (phase_r)
          PH_WAIT_ARRAY: begin
            if (b != CHR_STAR) begin
              phase_nxt      = PH_HALTED;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EXP_ARRAY;
            end else begin
              cmd_bytes_nxt  = USED_BITS'(1);
              line_bytes_nxt = '0;
              num_nxt        = '0;
              neg_nxt        = 1'b0;
              has_digit_nxt  = 1'b0;
              bad_nxt        = 1'b0;
              prev_cr_nxt    = 1'b0;
              phase_nxt      = PH_COUNT_LINE;
            end
          end
          PH_COUNT_LINE: begin
            if (too_long || (lf_done && !count_ok)) begin
              phase_nxt      = PH_HALTED;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_COUNT;
            end else if (lf_done) begin
              prev_cr_nxt  = 1'b0;
              exp_args_nxt = num_r[COUNT_BITS-1:0];
              cur_arg_nxt  = '0;
              if (num_r == '0) begin
                phase_nxt          = PH_WAIT_ARRAY;
                res_valid          = 1'b1;
                res.kind           = KIND_CMD_DONE;
                res.consumed_bytes = cmd_inc;
              end else begin
                phase_nxt = PH_WAIT_BULK;
              end
            end
          end
          PH_WAIT_BULK: begin
            if (b != CHR_DOLLAR) begin
              phase_nxt      = PH_HALTED;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EXP_BULK;
            end else begin
              line_bytes_nxt = '0;
              num_nxt        = '0;
              neg_nxt        = 1'b0;
              has_digit_nxt  = 1'b0;
              bad_nxt        = 1'b0;
              prev_cr_nxt    = 1'b0;
              phase_nxt      = PH_LEN_LINE;
            end
          end
          PH_LEN_LINE: begin
            if (too_long || (lf_done && !len_ok)) begin
              phase_nxt      = PH_HALTED;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_LEN;
            end else if (lf_done) begin
              prev_cr_nxt    = 1'b0;
              bytes_left_nxt = num_r[LENGTH_BITS-1:0];
              arg_len_nxt    = num_r[LENGTH_BITS-1:0];
              phase_nxt      = (num_r == '0) ? PH_TRAIL1 : PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
            res.arg_index    = cur_arg_r[INDEX_BITS-1:0];
            res.arg_length   = arg_len_r;
            res.arg_count    = exp_args_r;
            bytes_left_nxt   = bytes_left_r - 1'b1;
            if (bytes_left_r == LENGTH_BITS'(1)) begin
              phase_nxt = PH_TRAIL1;
            end
          end
          PH_TRAIL1: begin
            trail_ok_nxt = (b == CHR_CR);
            phase_nxt    = PH_TRAIL2;
          end
          PH_TRAIL2: begin
            res_valid = 1'b1;
            if (!trail_ok_r || (b != CHR_LF)) begin
              phase_nxt      = PH_HALTED;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NO_CRLF;
            end else begin
              res.arg_index  = cur_arg_r[INDEX_BITS-1:0];
              res.arg_length = arg_len_r;
              res.arg_count  = exp_args_r;
              if (last_arg) begin
                res.kind           = KIND_CMD_DONE;
                res.consumed_bytes = cmd_inc;
                phase_nxt          = PH_WAIT_ARRAY;
              end else begin
                res.kind    = KIND_ARG_DONE;
                cur_arg_nxt = cur_arg_r + 1'b1;
                phase_nxt   = PH_WAIT_BULK;
              end
            end
          end
          PH_HALTED: begin
            phase_nxt = PH_HALTED;
          end
          default: begin
            phase_nxt = PH_HALTED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_array_r <= MAX_ARRAY_RST;
      max_bulk_r  <= MAX_BULK_RST;
      max_line_r  <= MAX_LINE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_ARRAY: max_array_r <= cfg_wdata[COUNT_BITS-1:0];
        REG_MAX_BULK:  max_bulk_r  <= cfg_wdata[LENGTH_BITS-1:0];
        REG_MAX_LINE:  max_line_r  <= cfg_wdata[LINE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_req;
    end
    if (res_valid) begin
      out_resp_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_ARRAY;
      line_bytes_r <= '0;
      num_r        <= '0;
      neg_r        <= 1'b0;
      has_digit_r  <= 1'b0;
      bad_r        <= 1'b0;
      prev_cr_r    <= 1'b0;
      exp_args_r   <= '0;
      cur_arg_r    <= '0;
      bytes_left_r <= '0;
      arg_len_r    <= '0;
      trail_ok_r   <= 1'b0;
      cmd_bytes_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      line_bytes_r <= line_bytes_nxt;
      num_r        <= num_nxt;
      neg_r        <= neg_nxt;
      has_digit_r  <= has_digit_nxt;
      bad_r        <= bad_nxt;
      prev_cr_r    <= prev_cr_nxt;
      exp_args_r   <= exp_args_nxt;
      cur_arg_r    <= cur_arg_nxt;
      bytes_left_r <= bytes_left_nxt;
      arg_len_r    <= arg_len_nxt;
      trail_ok_r   <= trail_ok_nxt;
      cmd_bytes_r  <= cmd_bytes_nxt;
    end
  end

endmodule

>>> hw/rtl/rmp_checker.sv
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks for the RESP multibulk request parser, bound to the top.
// ----------------------------------------------------------------------------
`include "resp_multibulk_request_parser_defines.svh"

module rmp_checker
  import rmp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input rmp_req_t              in_req,
  input logic                  out_valid,
  input logic                  out_stall,
  input rmp_resp_t             out_resp,
  input logic                  cfg_we,
  input logic [CFG_ADDR_W-1:0] cfg_addr,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic unused_ok;
  assign unused_ok = in_valid ^ in_req.action ^ (^in_req.data_byte) ^ cfg_we ^
                     (^cfg_addr) ^ (^cfg_wdata);

  `RMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_resp), "result changed while stalled")

  `RMP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no blocked result")

  `RMP_ASSERT_NOW(a_err_clean, out_valid && (out_resp.kind == KIND_ERROR), (out_resp.error_code <= ERR_NO_CRLF) && (out_resp.arg_count == '0) && (out_resp.consumed_bytes == '0), "malformed error result")

  `RMP_ASSERT_NOW(a_cmd_count, out_valid && (out_resp.kind == KIND_CMD_DONE), ({1'b0, out_resp.arg_index} + 1'b1 == out_resp.arg_count) || ((out_resp.arg_count == '0) && (out_resp.arg_index == '0)), "command result not on its last argument")

endmodule

bind resp_multibulk_request_parser rmp_checker u_rmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_resp  (out_resp),
  .cfg_we    (cfg_we),
  .cfg_addr  (cfg_addr),
  .cfg_wdata (cfg_wdata)
);

>>> bench/resp_parse_checker.sv
// ----------------------------------------------------------------------------
// resp_parse_checker
// Watches the request, result and limit ports of the RESP multibulk parser,
// keeps its own model of the parse state and compares every result that the
// parser hands out with the one that model predicts, field by field.
// ----------------------------------------------------------------------------
module resp_parse_checker
  import rmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  rmp_req_t              in_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  rmp_resp_t             out_resp,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PS_WAIT_ARRAY, PS_COUNT_LINE, PS_WAIT_BULK, PS_LEN_LINE,
    PS_DATA, PS_TRAIL1, PS_TRAIL2, PS_HALTED
  } parse_phase_t;

  typedef enum logic [1:0] {LINE_MORE, LINE_DONE, LINE_LONG} line_ev_t;

  logic [COUNT_BITS-1:0]  lim_array;
  logic [LENGTH_BITS-1:0] lim_bulk;
  logic [LINE_BITS-1:0]   lim_line;

  parse_phase_t           phase;
  logic [LINE_BITS-1:0]   line_len;
  logic [NUM_BITS-1:0]    num_val;
  logic                   num_neg, num_digit, num_bad, saw_cr;
  logic [COUNT_BITS-1:0]  args_total, arg_cur;
  logic [LENGTH_BITS-1:0] data_left, arg_len;
  logic                   trail_cr_ok;
  logic [USED_BITS-1:0]   cmd_bytes;

  rmp_resp_t results_due[$];
  rmp_resp_t due;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(string msg);
    $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic void clear_line();
    line_len  = '0;
    num_val   = '0;
    num_neg   = 1'b0;
    num_digit = 1'b0;
    num_bad   = 1'b0;
    saw_cr    = 1'b0;
  endfunction

  function automatic void restart_parse();
    phase = PS_WAIT_ARRAY;
    clear_line();
    args_total  = '0;
    arg_cur     = '0;
    data_left   = '0;
    arg_len     = '0;
    trail_cr_ok = 1'b0;
    cmd_bytes   = '0;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [7:0] pay,
                                       logic [COUNT_BITS-1:0] idx,
                                       logic [LENGTH_BITS-1:0] len,
                                       logic [COUNT_BITS-1:0] cnt, logic [2:0] err,
                                       logic [USED_BITS-1:0] used);
    rmp_resp_t r;
    r.kind           = kind;
    r.payload_byte   = pay;
    r.arg_index      = idx[INDEX_BITS-1:0];
    r.arg_length     = len;
    r.arg_count      = cnt;
    r.error_code     = err;
    r.consumed_bytes = used;
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic void raise_error(logic [2:0] err);
    phase = PS_HALTED;
    queue_result(KIND_ERROR, '0, '0, '0, '0, err, '0);
  endfunction

  function automatic line_ev_t line_step(logic [7:0] b);
    logic [63:0] acc;
    if (saw_cr && b == CHR_LF) begin
      saw_cr = 1'b0;
      return LINE_DONE;
    end
    if (line_len >= lim_line) return LINE_LONG;
    if (saw_cr) begin
      num_bad = 1'b1;
      saw_cr  = 1'b0;
    end
    if (b == CHR_CR) begin
      saw_cr = 1'b1;
    end else if (b == CHR_MINUS && line_len == 0) begin
      num_neg = 1'b1;
    end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
      num_digit = 1'b1;
      acc = 64'(num_val) * 64'd10 + 64'(b - CHR_ZERO);
      num_val = (acc > 64'({NUM_BITS{1'b1}})) ? '1 : NUM_BITS'(acc);
    end else begin
      num_bad = 1'b1;
    end
    line_len++;
    return LINE_MORE;
  endfunction

  function automatic bit number_ok(logic [NUM_BITS-1:0] limit);
    if (!num_digit || num_bad) return 1'b0;
    if (num_neg) return num_val == '0;
    return num_val <= limit;
  endfunction

  function automatic void parse_req(rmp_req_t r);
    logic [7:0] b;
    line_ev_t   ev;
    b = r.data_byte;
    if (r.action == ACT_RESTART) begin
      restart_parse();
      return;
    end
    if (phase == PS_HALTED) return;
    if (phase == PS_WAIT_ARRAY) begin
      if (b != CHR_STAR) begin
        raise_error(ERR_EXP_ARRAY);
      end else begin
        cmd_bytes = USED_BITS'(1);
        clear_line();
        phase = PS_COUNT_LINE;
      end
      return;
    end
    if (cmd_bytes != '1) cmd_bytes++;
    case (phase)
      PS_COUNT_LINE: begin
        ev = line_step(b);
        if (ev == LINE_LONG) begin
          raise_error(ERR_BAD_COUNT);
        end else if (ev == LINE_DONE) begin
          if (!number_ok(NUM_BITS'(lim_array))) begin
            raise_error(ERR_BAD_COUNT);
          end else begin
            args_total = COUNT_BITS'(num_val);
            arg_cur = '0;
            if (args_total == '0) begin
              phase = PS_WAIT_ARRAY;
              queue_result(KIND_CMD_DONE, '0, '0, '0, '0, '0, cmd_bytes);
            end else begin
              phase = PS_WAIT_BULK;
            end
          end
        end
      end
      PS_WAIT_BULK: begin
        if (b != CHR_DOLLAR) begin
          raise_error(ERR_EXP_BULK);
        end else begin
          clear_line();
          phase = PS_LEN_LINE;
        end
      end
      PS_LEN_LINE: begin
        ev = line_step(b);
        if (ev == LINE_LONG) begin
          raise_error(ERR_BAD_LEN);
        end else if (ev == LINE_DONE) begin
          if (!number_ok(NUM_BITS'(lim_bulk))) begin
            raise_error(ERR_BAD_LEN);
          end else begin
            data_left = LENGTH_BITS'(num_val);
            arg_len   = LENGTH_BITS'(num_val);
            phase = (data_left == '0) ? PS_TRAIL1 : PS_DATA;
          end
        end
      end
      PS_DATA: begin
        queue_result(KIND_PAYLOAD, b, arg_cur, arg_len, args_total, '0, '0);
        data_left--;
        if (data_left == '0) phase = PS_TRAIL1;
      end
      PS_TRAIL1: begin
        trail_cr_ok = (b == CHR_CR);
        phase = PS_TRAIL2;
      end
      PS_TRAIL2: begin
        if (!trail_cr_ok || b != CHR_LF) begin
          raise_error(ERR_NO_CRLF);
        end else if ({1'b0, arg_cur} + 1'b1 >= {1'b0, args_total}) begin
          queue_result(KIND_CMD_DONE, '0, arg_cur, arg_len, args_total, '0, cmd_bytes);
          phase = PS_WAIT_ARRAY;
        end else begin
          queue_result(KIND_ARG_DONE, '0, arg_cur, arg_len, args_total, '0, '0);
          arg_cur++;
          phase = PS_WAIT_BULK;
        end
      end
      default: phase = PS_HALTED;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_array = MAX_ARRAY_RST;
      lim_bulk  = MAX_BULK_RST;
      lim_line  = MAX_LINE_RST;
      restart_parse();
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_ARRAY: lim_array = cfg_wdata[COUNT_BITS-1:0];
          REG_MAX_BULK:  lim_bulk  = cfg_wdata[LENGTH_BITS-1:0];
          REG_MAX_LINE:  lim_line  = cfg_wdata[LINE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_req(in_req);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report($sformatf("result with nothing expected, kind %0d", out_resp.kind));
        end else begin
          due = results_due.pop_front();
          check_field("kind", out_resp.kind, due.kind);
          check_field("payload_byte", out_resp.payload_byte, due.payload_byte);
          check_field("arg_index", out_resp.arg_index, due.arg_index);
          check_field("arg_length", out_resp.arg_length, due.arg_length);
          check_field("arg_count", out_resp.arg_count, due.arg_count);
          check_field("error_code", out_resp.error_code, due.error_code);
          check_field("consumed_bytes", out_resp.consumed_bytes, due.consumed_bytes);
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

>>> bench/tb_resp_multibulk_request_parser.sv
// ----------------------------------------------------------------------------
// tb_resp_multibulk_request_parser
// Feeds the RESP multibulk parser directed corner cases and random commands
// (well-formed, broken and cut short) under several limit settings, with
// random idling and stalls on both channels; resp_parse_checker judges results.
// ----------------------------------------------------------------------------
module tb_resp_multibulk_request_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import rmp_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [7:0] CRLF_MARK = 8'h7E;  // '~' in directed text stands for CR LF

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  rmp_req_t              in_req    = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  rmp_resp_t             out_resp;
  int                    fail_count;
  int                    results_owed;

  bit                    calm      = 1'b0;
  bit                    hold_long = 1'b0;
  bit                    tight     = 1'b0;
  int                    quiet     = 0;
  int                    items_sent = 0;
  int                    cur_array = 1024;
  int                    cur_bulk  = 536870912;
  int                    cur_line  = 64;
  logic [7:0]            cmd_q[$];

  resp_multibulk_request_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_resp  (out_resp),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  resp_parse_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_resp   (out_resp),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // result side: random stall per result, one long hold on request
  initial begin
    int n;
    forever begin
      n = draw_gap();
      if (hold_long) begin
        n = HOLD_CYCLES;
        hold_long = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_req(logic act, logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{action: act, data_byte: b};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic restart();
    send_req(ACT_RESTART, 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(int count_max, int bulk_max, int line_max);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MAX_ARRAY;
    cfg_wdata <= CFG_DATA_W'(count_max);
    @(posedge clk);
    cfg_addr  <= REG_MAX_BULK;
    cfg_wdata <= CFG_DATA_W'(bulk_max);
    @(posedge clk);
    cfg_addr  <= REG_MAX_LINE;
    cfg_wdata <= CFG_DATA_W'(line_max);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_array = count_max;
    cur_bulk  = bulk_max;
    cur_line  = line_max;
  endtask

  task automatic stage_byte(logic [7:0] v);
    cmd_q.insert(cmd_q.size(), v);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == CRLF_MARK) begin
        stage_byte(CHR_CR);
        stage_byte(CHR_LF);
      end else begin
        stage_byte(s[i]);
      end
    end
  endtask

  task automatic add_num(int unsigned v, bit neg, int zeros);
    if (neg) stage_byte(CHR_MINUS);
    repeat (zeros) stage_byte(CHR_ZERO);
    add_text({$sformatf("%0d", v), "~"});
  endtask

  task automatic flush_cmd();
    while (cmd_q.size() > 0) begin
      send_req(ACT_BYTE, cmd_q.pop_front());
      items_sent++;
    end
  endtask

  task automatic run_text(string s, bit then_restart);
    add_text(s);
    flush_cmd();
    if (then_restart) restart();
  endtask

  function automatic logic [7:0] data_byte_rand();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CHR_CR : CHR_LF;
    return 8'($urandom);
  endfunction

  task automatic random_command();
    int n, len, cut;
    bit broken;
    broken = 1'b0;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 11) == 0) restart();
    n = $urandom_range(0, (cur_array < 4) ? cur_array : 4);
    if ($urandom_range(0, 19) == 0) begin
      n = cur_array + 1;
      broken = 1'b1;
    end
    add_text("*");
    add_num(n, n == 0 && $urandom_range(0, 3) == 0,
            ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    for (int i = 0; i < n && !broken; i++) begin
      len = $urandom_range(0, (cur_bulk < 8) ? cur_bulk : 8);
      if ($urandom_range(0, 24) == 0) len = (cur_bulk < 40) ? cur_bulk : 40;
      if ($urandom_range(0, 29) == 0) begin
        len = cur_bulk + 1;
        broken = 1'b1;
      end
      add_text("$");
      add_num(len, len == 0 && $urandom_range(0, 3) == 0,
              ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
      if (!broken) begin
        repeat (len) stage_byte(data_byte_rand());
        add_text("~");
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cmd_q[$urandom_range(0, cmd_q.size() - 1)] = 8'($urandom);
      broken = 1'b1;
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, cmd_q.size() - 1);
      while (cmd_q.size() > cut) void'(cmd_q.pop_back());
      broken = 1'b1;
    end
    flush_cmd();
    if (broken || tight) begin
      repeat ($urandom_range(0, 3)) send_req(ACT_BYTE, 8'($urandom));
      restart();
    end
  endtask

  task automatic random_phase(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) random_command();
    calm = 1'b0;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default limits: framing corner cases and every error code
    run_text("*0~", 0);
    run_text("*2~$3~SET~$0~~", 0);
    run_text("*-0~", 0);
    run_text("*1~$-0~~", 0);
    run_text("*-1~*0~", 1);
    run_text("x*0~", 1);
    run_text("*1~X", 1);
    run_text("*1~$-2~", 1);
    run_text("*1~$1~AB\015", 1);
    run_text("*1~$1~A\015X", 1);
    run_text("*1\015~", 1);
    run_text("*~", 1);
    run_text("*1~$~", 1);
    run_text("*1024~$0~~", 1);
    run_text("*1025~", 1);
    add_text("*1~$536870912~");
    stage_byte(8'h00);
    stage_byte(8'hFF);
    run_text("", 1);
    run_text("*1~$536870913~", 1);
    run_text("*99999999999999999999~", 1);
    add_text("*");
    repeat (65) stage_byte(CHR_ZERO);
    run_text("", 1);
    add_text("*");
    repeat (62) stage_byte(CHR_ZERO);
    run_text("1~$0~~", 0);
    run_text("*2~$1~Z", 1);
    add_text("*1~$1~");
    stage_byte(8'hFF);
    run_text("~", 0);
    random_phase(500);

    set_limits(1024, 536870912, 127);
    random_phase(500);

    tight = 1'b1;
    set_limits(3, 12, 4);
    random_phase(350);

    set_limits(0, 0, 3);
    run_text("*0~", 0);
    run_text("*1~", 1);
    random_phase(80);
    set_limits(0, 0, 0);
    run_text("*5", 1);
    settle();
    set_limits(0, 0, 1);
    run_text("*~", 1);
    settle();
    tight = 1'b0;

    // receiver holds off while a long argument streams in
    set_limits(6, 40, 10);
    calm = 1'b1;
    hold_long = 1'b1;
    add_text("*2~$40~");
    repeat (40) stage_byte(data_byte_rand());
    run_text("~$1~q~", 0);
    random_phase(500);

    settle();
    if (fail_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rmp_pkg.sv
hw/rtl/resp_multibulk_request_parser.sv
hw/rtl/rmp_checker.sv
bench/resp_parse_checker.sv
bench/tb_resp_multibulk_request_parser.sv
